[hdl/mstfd_pkg.sv]
// ----------------------------------------------------------------------------
// mstfd_pkg: shared types and constants of the stereo multitap delay
// Register map, field positions, sequencer states and the per-tap micro
// schedule that drives the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package mstfd_pkg;

	// Default values of the top-level parameters.
	localparam int DEF_RING_DEPTH  = 65536;
	localparam int DEF_TAP_COUNT   = 4;
	localparam int DEF_SAMPLE_BITS = 16;
	localparam int DEF_COEF_BITS   = 16;

	// Configuration port.
	localparam int CFG_INDEX_BITS = 4;
	localparam int CFG_DATA_BITS  = 50;
	localparam int WORD_A_BITS    = 50;
	localparam int WORD_B_BITS    = 48;
	localparam int REG_TAPS       = 4;

	localparam logic [CFG_INDEX_BITS-1:0] REG_WORD_A0 = 4'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WORD_B0 = 4'd4;

	// Field positions in word_a and word_b.
	localparam int DELAY_BITS = 17;
	localparam int ENABLE_POS = 17;
	localparam int LEVEL_POS  = 18;
	localparam int PAN_POS    = 34;
	localparam int FBK_POS    = 0;
	localparam int SWAP_POS   = 16;
	localparam int LPC_POS    = 32;

	localparam logic [WORD_A_BITS-1:0] WORD_A_RESET [REG_TAPS] = '{
		50'd13744083258, 50'd13743956596, 50'd13743960976, 50'd13743965416
	};
	localparam logic [WORD_B_BITS-1:0] WORD_B_RESET = 48'd90048284327936;

	// Unity pan gain in Q1.14.
	localparam int PAN_ONE = 16384;

	// Sequencer states.
	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_SETUP  = 6'b000100,
		ST_REDUCE = 6'b001000,
		ST_RUN    = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	// Operand pair fed to the multiplier.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_RL_GL,
		OP_RR_GR,
		OP_TL_LV,
		OP_TR_LV,
		OP_TL_OMC,
		OP_LPL_C,
		OP_TR_OMC,
		OP_LPR_C,
		OP_YL_FB,
		OP_YR_FB,
		OP_FR_SW,
		OP_FL_OMS,
		OP_FL_SW,
		OP_FR_OMS
	} op_sel_t;

	// Register that takes the rounded, saturated accumulator.
	typedef enum logic [3:0] {
		CAP_NONE,
		CAP_XL_FB,
		CAP_XR_FB,
		CAP_XL,
		CAP_XR,
		CAP_YL,
		CAP_YR,
		CAP_FL,
		CAP_FR,
		CAP_NL,
		CAP_NR
	} cap_sel_t;

	typedef struct packed {
		op_sel_t  op;
		logic     add;
		cap_sel_t cap;
	} uop_t;

	// Control from the sequencer to the multiply-accumulate unit.
	typedef struct packed {
		logic issue;
		logic acc_add;
		logic rnd14;
	} mac_ctrl_t;

	localparam int STEP_BITS = 5;
	localparam logic [STEP_BITS-1:0] STEP_LAST = 5'd22;

	// Per-tap schedule. A product issued at a step is registered in the
	// multiplier stage and then in the accumulator, where a capture may take it.
	function automatic uop_t uop_at(input logic [STEP_BITS-1:0] step);
		uop_t u;
		u = '{op: OP_NONE, add: 1'b0, cap: CAP_NONE};
		unique case (step)
			5'd1:  u.op = OP_RL_GL;
			5'd2:  u.op = OP_RR_GR;
			5'd3:  u.cap = CAP_XL_FB;
			5'd4:  u = '{op: OP_TL_LV, add: 1'b0, cap: CAP_XR_FB};
			5'd5:  u.op = OP_TR_LV;
			5'd6:  u.cap = CAP_XL;
			5'd7:  u = '{op: OP_TL_OMC, add: 1'b0, cap: CAP_XR};
			5'd8:  u = '{op: OP_LPL_C, add: 1'b1, cap: CAP_NONE};
			5'd9:  u.op = OP_TR_OMC;
			5'd10: u = '{op: OP_LPR_C, add: 1'b1, cap: CAP_YL};
			5'd11: u.op = OP_YL_FB;
			5'd12: u.cap = CAP_YR;
			5'd13: u = '{op: OP_YR_FB, add: 1'b0, cap: CAP_FL};
			5'd15: u.cap = CAP_FR;
			5'd16: u.op = OP_FR_SW;
			5'd17: u = '{op: OP_FL_OMS, add: 1'b1, cap: CAP_NONE};
			5'd18: u.op = OP_FL_SW;
			5'd19: u = '{op: OP_FR_OMS, add: 1'b1, cap: CAP_NL};
			5'd21: u.cap = CAP_NR;
			default: u = '{op: OP_NONE, add: 1'b0, cap: CAP_NONE};
		endcase
		return u;
	endfunction

endpackage

[hdl/mstfd_mac.sv]
// ----------------------------------------------------------------------------
// mstfd_mac: shared multiply-accumulate unit
// One registered multiplier, an accumulator behind it, and a rounding and
// saturation stage that brings the accumulator back to sample scale.
// ----------------------------------------------------------------------------
module mstfd_mac import mstfd_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int COEF_BITS   = DEF_COEF_BITS,
	parameter int OPB_BITS    = DEF_COEF_BITS + 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mac_ctrl_t                     ctrl,
	input  logic signed [SAMPLE_BITS-1:0] op_a,
	input  logic signed [OPB_BITS-1:0]    op_b,
	input  logic signed [SAMPLE_BITS-1:0] addend,
	output logic signed [SAMPLE_BITS-1:0] result
);

	localparam int PW = SAMPLE_BITS + OPB_BITS;
	localparam int AC = PW + 1;
	localparam int TW = AC + 3;
	localparam logic signed [TW-1:0] SMAX = TW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [TW-1:0] SMIN = -SMAX - TW'(1);

	logic signed [PW-1:0] prod_s1;
	logic                 vld_s1;
	logic                 add_s1;
	logic signed [AC-1:0] acc_q;

	// Issue flags are registered in the same stage as the product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			add_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctrl.issue;
			add_s1 <= ctrl.acc_add;
		end
	end

	// Multiplier and accumulator registers.
	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		if (vld_s1) begin
			acc_q <= (add_s1 ? acc_q : AC'(0)) + AC'(prod_s1);
		end
	end

	// Round to nearest with halves away from zero, add, then saturate.
	logic              neg;
	logic [AC-1:0]     mag;
	logic [AC:0]       sum14, sumc, r;
	logic signed [TW-1:0] sv_p, sv, tot;

	always_comb begin
		neg   = acc_q[AC-1];
		mag   = neg ? AC'(-acc_q) : AC'(acc_q);
		sum14 = {1'b0, mag} + (AC+1)'(1 << 13);
		sumc  = {1'b0, mag} + (AC+1)'(1 << (COEF_BITS - 1));
		r     = ctrl.rnd14 ? (sum14 >> 14) : (sumc >> COEF_BITS);
		sv_p  = signed'({2'b00, r});
		sv    = neg ? -sv_p : sv_p;
		tot   = sv + TW'(addend);
		if (tot > SMAX) begin
			result = SMAX[SAMPLE_BITS-1:0];
		end else if (tot < SMIN) begin
			result = SMIN[SAMPLE_BITS-1:0];
		end else begin
			result = tot[SAMPLE_BITS-1:0];
		end
	end

`ifndef NO_ASSERTIONS
	// An accumulating product always follows one that was issued before it.
	a_add_follows_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && add_s1) |-> $past(vld_s1, 1))
		else $error("accumulate without a preceding product");
	// The issue flags of a product are seen in the next cycle.
	a_issue_delay: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.issue |=> vld_s1)
		else $error("issued product lost");
	// A product flag is raised only for an issued product.
	a_add_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(!ctrl.issue) |=> !vld_s1)
		else $error("product flag without issue");
`endif

endmodule

[hdl/multitap_stereo_feedback_delay_top.sv]
// ----------------------------------------------------------------------------
// multitap_stereo_feedback_delay_top: stereo multitap delay with feedback
// Writes each frame into a history ring, runs every enabled tap through
// pan, feedback, level, lowpass and cross-feedback, and outputs dry plus taps.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the history ring and the
// feedback store of min(TAP_COUNT,4) * RING_DEPTH entries and accepts no
// frame until it ends; configuration writes are taken throughout. A frame
// then passes through a setup state for each tap and, for each enabled tap,
// R = 18 - clog2(RING_DEPTH) delay reduction steps (2 at the defaults) and
// a run of the per-tap schedule. The single shared multiplier performs the
// fourteen products of each enabled tap in turn.
// ----------------------------------------------------------------------------
module multitap_stereo_feedback_delay_top import mstfd_pkg::*; #(
	parameter int RING_DEPTH  = DEF_RING_DEPTH,
	parameter int TAP_COUNT   = DEF_TAP_COUNT,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int COEF_BITS   = DEF_COEF_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] left_in,
	input  logic signed [SAMPLE_BITS-1:0] right_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

	localparam int S      = SAMPLE_BITS;
	localparam int NT     = (TAP_COUNT > REG_TAPS) ? REG_TAPS : TAP_COUNT;
	localparam int TW     = (NT > 1) ? $clog2(NT) : 1;
	localparam int AW     = $clog2(RING_DEPTH);
	localparam int FDEPTH = NT * RING_DEPTH;
	localparam int FAW    = $clog2(FDEPTH);
	localparam int OPB    = ((COEF_BITS > 15) ? COEF_BITS : 15) + 2;
	localparam int RED_STEPS = 18 - $clog2(RING_DEPTH);
	localparam int DW     = S + 4;
	localparam logic signed [DW-1:0] DMAX = DW'((64'sd1 <<< (S - 1)) - 64'sd1);
	localparam logic signed [DW-1:0] DMIN = -DMAX - DW'(1);

	// Memories.
	logic [2*S-1:0] ring_mem [RING_DEPTH];
	logic [2*S-1:0] fb_mem   [FDEPTH];
	logic [2*S-1:0] ring_rd_q, fb_rd_q;

	// Configuration registers.
	logic [WORD_A_BITS-1:0] word_a_q [NT];
	logic [WORD_B_BITS-1:0] word_b_q [NT];

	// Sequencer and state.
	state_t               state_q;
	logic [TW-1:0]        tap_q;
	logic [STEP_BITS-1:0] step_q;
	logic [3:0]           rstep_q;
	logic [DELAY_BITS-1:0] dm_q;
	logic [AW-1:0]        wp_q;
	logic [AW-1:0]        fpos_q [NT];
	logic [FAW-1:0]       fb_base_q;
	logic [FAW-1:0]       clr_q;
	logic signed [S-1:0]  lp_l_q [NT];
	logic signed [S-1:0]  lp_r_q [NT];
	logic signed [DW-1:0] dry_l_q, dry_r_q;
	logic                 out_valid_q;
	logic signed [S-1:0]  out_l_q, out_r_q;

	// Working registers of one tap.
	logic signed [S-1:0] xl_q, xr_q, yl_q, yr_q, fl_q, fr_q;

	// Tap fields.
	logic [WORD_A_BITS-1:0] wa;
	logic [WORD_B_BITS-1:0] wb;
	logic [DELAY_BITS-1:0]  delay;
	logic                   tap_en;
	logic [COEF_BITS-1:0]   level, fbk, swp, lpc;
	logic [COEF_BITS:0]     omc, oms;
	logic signed [17:0]     pan_w, gl_raw, gr_raw;
	logic [14:0]            gl, gr;

	function automatic logic [COEF_BITS-1:0] align(input logic [15:0] g);
		logic [COEF_BITS+15:0] w;
		w = (COEF_BITS+16)'(g) << COEF_BITS;
		return w[COEF_BITS+15:16];
	endfunction

	// Decode the fields of the current tap.
	always_comb begin
		wa     = word_a_q[tap_q];
		wb     = word_b_q[tap_q];
		delay  = wa[DELAY_BITS-1:0];
		tap_en = wa[ENABLE_POS];
		level  = align(wa[LEVEL_POS +: 16]);
		fbk    = align(wb[FBK_POS +: 16]);
		swp    = align(wb[SWAP_POS +: 16]);
		lpc    = align(wb[LPC_POS +: 16]);
		omc    = (COEF_BITS+1)'(1 << COEF_BITS) - (COEF_BITS+1)'(lpc);
		oms    = (COEF_BITS+1)'(1 << COEF_BITS) - (COEF_BITS+1)'(swp);
		pan_w  = 18'(signed'(wa[PAN_POS +: 16]));
		gl_raw = 18'sd16384 - pan_w;
		gr_raw = 18'sd16384 + pan_w;
		gl = (gl_raw < 0) ? 15'd0 : (gl_raw > 18'sd16384) ? 15'(PAN_ONE) : gl_raw[14:0];
		gr = (gr_raw < 0) ? 15'd0 : (gr_raw > 18'sd16384) ? 15'(PAN_ONE) : gr_raw[14:0];
	end

	// Read addresses.
	logic [AW:0]    rd_sum;
	logic [AW-1:0]  rd_addr;
	logic [FAW-1:0] fb_addr;

	always_comb begin
		rd_sum  = (AW+1)'(wp_q) + (AW+1)'(RING_DEPTH) - (AW+1)'(dm_q);
		rd_addr = (32'(rd_sum) >= RING_DEPTH) ? AW'(32'(rd_sum) - RING_DEPTH) : rd_sum[AW-1:0];
		fb_addr = fb_base_q + FAW'(fpos_q[tap_q]);
	end

	// Micro schedule and multiplier operands.
	uop_t                uop;
	mac_ctrl_t           mctl;
	logic signed [S-1:0] op_a, addend, mac_res;
	logic signed [OPB-1:0] op_b;
	logic signed [S-1:0] ring_l, ring_r, fb_l, fb_r;

	always_comb begin
		uop    = uop_at(step_q);
		ring_l = ring_rd_q[2*S-1:S];
		ring_r = ring_rd_q[S-1:0];
		fb_l   = fb_rd_q[2*S-1:S];
		fb_r   = fb_rd_q[S-1:0];
		op_a   = '0;
		op_b   = '0;
		case (uop.op)
			OP_RL_GL:  begin op_a = ring_l;        op_b = OPB'(gl);    end
			OP_RR_GR:  begin op_a = ring_r;        op_b = OPB'(gr);    end
			OP_TL_LV:  begin op_a = xl_q;          op_b = OPB'(level); end
			OP_TR_LV:  begin op_a = xr_q;          op_b = OPB'(level); end
			OP_TL_OMC: begin op_a = xl_q;          op_b = OPB'(omc);   end
			OP_LPL_C:  begin op_a = lp_l_q[tap_q]; op_b = OPB'(lpc);   end
			OP_TR_OMC: begin op_a = xr_q;          op_b = OPB'(omc);   end
			OP_LPR_C:  begin op_a = lp_r_q[tap_q]; op_b = OPB'(lpc);   end
			OP_YL_FB:  begin op_a = yl_q;          op_b = OPB'(fbk);   end
			OP_YR_FB:  begin op_a = yr_q;          op_b = OPB'(fbk);   end
			OP_FR_SW:  begin op_a = fr_q;          op_b = OPB'(swp);   end
			OP_FL_OMS: begin op_a = fl_q;          op_b = OPB'(oms);   end
			OP_FL_SW:  begin op_a = fl_q;          op_b = OPB'(swp);   end
			OP_FR_OMS: begin op_a = fr_q;          op_b = OPB'(oms);   end
			default:   begin op_a = '0;            op_b = '0;          end
		endcase
		mctl.issue   = (state_q == ST_RUN) && (uop.op != OP_NONE);
		mctl.acc_add = uop.add;
		mctl.rnd14   = (uop.cap == CAP_XL_FB) || (uop.cap == CAP_XR_FB);
		addend = (uop.cap == CAP_XL_FB) ? fb_l : (uop.cap == CAP_XR_FB) ? fb_r : '0;
	end

	mstfd_mac #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COEF_BITS  (COEF_BITS),
		.OPB_BITS   (OPB)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (mctl),
		.op_a  (op_a),
		.op_b  (op_b),
		.addend(addend),
		.result(mac_res)
	);

	// Memory write ports.
	logic           accept, last_step, clr_done, ring_we, fb_we;
	logic [AW-1:0]  ring_wa;
	logic [FAW-1:0] fb_wa;
	logic [2*S-1:0] ring_wd, fb_wd;

	always_comb begin
		accept    = in_valid && in_ready;
		last_step = (state_q == ST_RUN) && (step_q == STEP_LAST);
		clr_done  = (32'(clr_q) == FDEPTH - 1);
		if (state_q == ST_CLEAR) begin
			ring_we = (32'(clr_q) < RING_DEPTH);
			ring_wa = clr_q[AW-1:0];
			ring_wd = '0;
			fb_we   = 1'b1;
			fb_wa   = clr_q;
			fb_wd   = '0;
		end else begin
			ring_we = accept;
			ring_wa = wp_q;
			ring_wd = {left_in, right_in};
			fb_we   = last_step;
			fb_wa   = fb_addr;
			fb_wd   = {xl_q, xr_q};
		end
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_wa] <= ring_wd;
		end
		if (fb_we) begin
			fb_mem[fb_wa] <= fb_wd;
		end
		ring_rd_q <= ring_mem[rd_addr];
		fb_rd_q   <= fb_mem[fb_addr];
	end

	// Capture of rounded results into the working registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_RUN) begin
			case (uop.cap) inside
				CAP_XL_FB, CAP_XL, CAP_NL: xl_q <= mac_res;
				CAP_XR_FB, CAP_XR, CAP_NR: xr_q <= mac_res;
				CAP_YL: yl_q <= mac_res;
				CAP_YR: yr_q <= mac_res;
				CAP_FL: fl_q <= mac_res;
				CAP_FR: fr_q <= mac_res;
				default: ;
			endcase
		end
	end

	// Feedback position after this tap's advance.
	logic [AW:0]            fpos_nxt;
	logic                   fpos_wrap;
	logic [DELAY_BITS+1:0]  red_lim;
	logic                   last_tap;

	always_comb begin
		fpos_nxt  = (AW+1)'(fpos_q[tap_q]) + (AW+1)'(1);
		fpos_wrap = ((DELAY_BITS+1)'(fpos_nxt) >= (DELAY_BITS+1)'(delay)) ||
			(32'(fpos_nxt) >= RING_DEPTH);
		red_lim   = (DELAY_BITS+2)'(RING_DEPTH) << rstep_q;
		last_tap  = (32'(tap_q) == NT - 1);
	end

	// Sequencer, configuration and tap state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			tap_q       <= '0;
			step_q      <= '0;
			rstep_q     <= '0;
			dm_q        <= '0;
			wp_q        <= '0;
			fb_base_q   <= '0;
			clr_q       <= '0;
			dry_l_q     <= '0;
			dry_r_q     <= '0;
			out_valid_q <= 1'b0;
			for (int t = 0; t < NT; t++) begin
				word_a_q[t] <= WORD_A_RESET[t];
				word_b_q[t] <= WORD_B_RESET;
				fpos_q[t]   <= '0;
				lp_l_q[t]   <= '0;
				lp_r_q[t]   <= '0;
			end
		end else begin
			// Configuration writes are taken at any time.
			if (cfg_valid) begin
				for (int t = 0; t < NT; t++) begin
					if (cfg_index == REG_WORD_A0 + CFG_INDEX_BITS'(t)) begin
						word_a_q[t] <= cfg_data[WORD_A_BITS-1:0];
					end
					if (cfg_index == REG_WORD_B0 + CFG_INDEX_BITS'(t)) begin
						word_b_q[t] <= cfg_data[WORD_B_BITS-1:0];
					end
				end
			end

			// A taken result drops the flag; the finish state sets it itself.
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + FAW'(1);
					if (clr_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						dry_l_q   <= DW'(left_in);
						dry_r_q   <= DW'(right_in);
						tap_q     <= '0;
						fb_base_q <= '0;
						state_q   <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if (tap_en) begin
						dm_q    <= delay;
						rstep_q <= 4'(RED_STEPS - 1);
						state_q <= ST_REDUCE;
					end else if (last_tap) begin
						state_q <= ST_DONE;
					end else begin
						tap_q     <= tap_q + TW'(1);
						fb_base_q <= fb_base_q + FAW'(RING_DEPTH);
					end
				end
				ST_REDUCE: begin
					// Delay modulo the ring depth, one conditional subtract a step.
					if ((DELAY_BITS+2)'(dm_q) >= red_lim) begin
						dm_q <= dm_q - red_lim[DELAY_BITS-1:0];
					end
					if (rstep_q == 4'd0) begin
						step_q  <= '0;
						state_q <= ST_RUN;
					end else begin
						rstep_q <= rstep_q - 4'd1;
					end
				end
				ST_RUN: begin
					if (last_step) begin
						lp_l_q[tap_q] <= yl_q;
						lp_r_q[tap_q] <= yr_q;
						dry_l_q <= dry_l_q + DW'(yl_q);
						dry_r_q <= dry_r_q + DW'(yr_q);
						fpos_q[tap_q] <= fpos_wrap ? AW'(0) : fpos_nxt[AW-1:0];
						if (last_tap) begin
							state_q <= ST_DONE;
						end else begin
							tap_q     <= tap_q + TW'(1);
							fb_base_q <= fb_base_q + FAW'(RING_DEPTH);
							state_q   <= ST_SETUP;
						end
					end else begin
						step_q <= step_q + STEP_BITS'(1);
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						wp_q <= (32'(wp_q) == RING_DEPTH - 1) ? AW'(0) : wp_q + AW'(1);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Saturated output registers.
	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && (!out_valid_q || out_ready)) begin
			out_l_q <= (dry_l_q > DMAX) ? DMAX[S-1:0] :
				(dry_l_q < DMIN) ? DMIN[S-1:0] : dry_l_q[S-1:0];
			out_r_q <= (dry_r_q > DMAX) ? DMAX[S-1:0] :
				(dry_r_q < DMIN) ? DMIN[S-1:0] : dry_r_q[S-1:0];
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign left_out  = out_l_q;
	assign right_out = out_r_q;

`ifndef NO_ASSERTIONS
	// A result appears only when a frame finishes.
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the finish state");
	// The reduced delay is inside the ring while a tap runs.
	a_delay_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (32'(dm_q) < RING_DEPTH))
		else $error("delay not reduced modulo ring depth");
	// Feedback positions stay inside the store row of their tap.
	a_fpos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(fpos_q[tap_q]) < RING_DEPTH))
		else $error("feedback position out of range");
	// A frame is accepted only after the clearing pass has finished.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (state_q != ST_CLEAR) && (ring_wa == wp_q))
		else $error("frame accepted during clearing pass");
`endif

endmodule

[bench/multitap_stereo_feedback_delay_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multitap_stereo_feedback_delay_top_tb: self-checking bench of the delay top
// Drives stereo frames and register writes over valid/ready channels and keeps
// its own copy of the ring, feedback store and lowpass state. Every output
// frame is checked against the frame predicted when its request was accepted.
// ----------------------------------------------------------------------------
module multitap_stereo_feedback_delay_top_tb;
	import mstfd_pkg::*;

	localparam int RING    = DEF_RING_DEPTH;
	localparam int TAPS    = DEF_TAP_COUNT;
	localparam int CYCLE_LIMIT = 4000000;
	localparam longint ONE_Q16 = 64'sd65536;

	typedef struct {
		logic signed [15:0] left;
		logic signed [15:0] right;
	} frame_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] left_in = '0;
	logic signed [15:0] right_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] left_out;
	logic signed [15:0] right_out;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	// Predictor state: registers, history ring, feedback store, lowpass memory.
	logic [WORD_A_BITS-1:0] tap_word_a [TAPS];
	logic [WORD_B_BITS-1:0] tap_word_b [TAPS];
	int hist_l [RING];
	int hist_r [RING];
	int fbk_l [TAPS*RING];
	int fbk_r [TAPS*RING];
	int fbk_pos [TAPS];
	int lowpass_l [TAPS];
	int lowpass_r [TAPS];
	int wr_pos;

	frame_t expected_frames [$];
	int mismatch_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	multitap_stereo_feedback_delay_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.left_in(left_in), .right_in(right_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.left_out(left_out), .right_out(right_out),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("multitap_stereo_feedback_delay_top_tb failed");
			$finish;
		end
	end

	function automatic longint sat_sample(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// Divide by 2^k, rounding to nearest with halves away from zero.
	function automatic longint round_shift(longint v, int k);
		longint m;
		m = (v < 0) ? -v : v;
		m = (m + (64'sd1 <<< (k - 1))) >>> k;
		return (v < 0) ? -m : m;
	endfunction

	function automatic longint clamp_pan_gain(longint g);
		if (g < 0) return 0;
		if (g > PAN_ONE) return PAN_ONE;
		return g;
	endfunction

	function automatic void reset_delay_state();
		for (int t = 0; t < TAPS; t++) begin
			tap_word_a[t] = WORD_A_RESET[t];
			tap_word_b[t] = WORD_B_RESET;
			fbk_pos[t] = 0;
			lowpass_l[t] = 0;
			lowpass_r[t] = 0;
		end
		for (int i = 0; i < RING; i++) begin
			hist_l[i] = 0;
			hist_r[i] = 0;
		end
		for (int i = 0; i < TAPS*RING; i++) begin
			fbk_l[i] = 0;
			fbk_r[i] = 0;
		end
		wr_pos = 0;
	endfunction

	function automatic void apply_reg_write(logic [CFG_INDEX_BITS-1:0] idx,
			logic [CFG_DATA_BITS-1:0] data);
		if (idx >= REG_WORD_A0 && idx < REG_WORD_A0 + REG_TAPS)
			tap_word_a[idx - REG_WORD_A0] = data[WORD_A_BITS-1:0];
		else if (idx >= REG_WORD_B0 && idx < REG_WORD_B0 + REG_TAPS)
			tap_word_b[idx - REG_WORD_B0] = data[WORD_B_BITS-1:0];
	endfunction

	// Run one frame through the delay network and return the mixed output.
	function automatic frame_t mix_frame(logic signed [15:0] xl, logic signed [15:0] xr);
		longint accl, accr, level, pan, gl, gr, fb, swp, c;
		longint tl, tr, yl, yr, fl, fr;
		int delay, rd, fi;
		frame_t res;
		accl = longint'(xl);
		accr = longint'(xr);
		hist_l[wr_pos] = int'(xl);
		hist_r[wr_pos] = int'(xr);
		for (int t = 0; t < TAPS; t++) begin
			if (tap_word_a[t][ENABLE_POS]) begin
				delay = int'(tap_word_a[t][DELAY_BITS-1:0]);
				level = tap_word_a[t][LEVEL_POS +: 16];
				pan = $signed(tap_word_a[t][PAN_POS +: 16]);
				gl = clamp_pan_gain(PAN_ONE - pan);
				gr = clamp_pan_gain(PAN_ONE + pan);
				fb = tap_word_b[t][FBK_POS +: 16];
				swp = tap_word_b[t][SWAP_POS +: 16];
				c = tap_word_b[t][LPC_POS +: 16];
				rd = (wr_pos + RING - (delay % RING)) % RING;
				fi = t * RING + fbk_pos[t];
				tl = sat_sample(round_shift(hist_l[rd] * gl, 14) + fbk_l[fi]);
				tr = sat_sample(round_shift(hist_r[rd] * gr, 14) + fbk_r[fi]);
				tl = sat_sample(round_shift(tl * level, 16));
				tr = sat_sample(round_shift(tr * level, 16));
				yl = sat_sample(round_shift(tl * (ONE_Q16 - c) + lowpass_l[t] * c, 16));
				yr = sat_sample(round_shift(tr * (ONE_Q16 - c) + lowpass_r[t] * c, 16));
				lowpass_l[t] = int'(yl);
				lowpass_r[t] = int'(yr);
				accl += yl;
				accr += yr;
				fl = sat_sample(round_shift(yl * fb, 16));
				fr = sat_sample(round_shift(yr * fb, 16));
				fbk_l[fi] = int'(sat_sample(round_shift(swp * fr + (ONE_Q16 - swp) * fl, 16)));
				fbk_r[fi] = int'(sat_sample(round_shift(swp * fl + (ONE_Q16 - swp) * fr, 16)));
				fbk_pos[t]++;
				if (fbk_pos[t] >= delay || fbk_pos[t] >= RING)
					fbk_pos[t] = 0;
			end
		end
		wr_pos = (wr_pos + 1) % RING;
		res.left = 16'(sat_sample(accl));
		res.right = 16'(sat_sample(accr));
		return res;
	endfunction

	// Send one frame; valid stays high afterwards so back-to-back requests
	// never lower and raise it in the same step.
	task automatic send_frame(logic signed [15:0] l, logic signed [15:0] r);
		frame_t want;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		left_in <= l;
		right_in <= r;
		do @(posedge clk); while (!in_ready);
		want = mix_frame(l, r);
		expected_frames.insert(expected_frames.size(), want);
	endtask

	task automatic send_random_frame();
		logic signed [15:0] l, r;
		l = 16'($urandom);
		r = 16'($urandom);
		// Push a share of frames to full scale to drive saturation.
		if ($urandom_range(0, 9) == 0) l = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
		if ($urandom_range(0, 9) == 0) r = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
		send_frame(l, r);
	endtask

	// Wait for every expected frame, then let the block settle.
	task automatic drain_outputs();
		in_valid <= 1'b0;
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Register write; the caller lowers valid with end_reg_writes.
	task automatic write_reg(int idx, logic [CFG_DATA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_INDEX_BITS'(idx);
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg_write(CFG_INDEX_BITS'(idx), data);
	endtask

	task automatic end_reg_writes();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [WORD_A_BITS-1:0] pack_word_a(int delay, bit en,
			logic [15:0] level, logic [15:0] pan);
		logic [WORD_A_BITS-1:0] w;
		w = '0;
		w[DELAY_BITS-1:0] = DELAY_BITS'(delay);
		w[ENABLE_POS] = en;
		w[LEVEL_POS +: 16] = level;
		w[PAN_POS +: 16] = pan;
		return w;
	endfunction

	function automatic logic [WORD_B_BITS-1:0] pack_word_b(logic [15:0] fb,
			logic [15:0] swp, logic [15:0] c);
		return {c, swp, fb};
	endfunction

	function automatic int random_delay();
		case ($urandom_range(0, 9))
			0: return RING + int'($urandom_range(0, 3));
			1: return int'($urandom_range(0, (1 << DELAY_BITS) - 1));
			default: return int'($urandom_range(0, 40));
		endcase
	endfunction

	// Random setting of all eight registers, with extremes mixed in.
	task automatic write_random_taps();
		logic [15:0] lv, pn, fb, sw, lc;
		logic [CFG_DATA_BITS-1:0] data;
		for (int t = 0; t < TAPS; t++) begin
			lv = $urandom_range(0, 3) == 0 ? 16'hffff : 16'($urandom);
			pn = $urandom_range(0, 4) == 0 ? 16'h8000 : 16'($urandom);
			write_reg(REG_WORD_A0 + t, pack_word_a(random_delay(), $urandom_range(0, 3) != 0,
				lv, pn));
			fb = $urandom_range(0, 3) == 0 ? 16'hffff : 16'($urandom);
			sw = 16'($urandom);
			lc = $urandom_range(0, 3) == 0 ? 16'h0000 : 16'($urandom);
			data = CFG_DATA_BITS'({$urandom, $urandom});
			data[WORD_B_BITS-1:0] = pack_word_b(fb, sw, lc);
			write_reg(REG_WORD_B0 + t, data);
		end
		end_reg_writes();
	endtask

	// Output checker and receiver stall pattern.
	always @(posedge clk) begin
		frame_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_frames.size() == 0) begin
				$error("output frame with none expected: left_out %0d right_out %0d",
					left_out, right_out);
				mismatch_count++;
			end else begin
				want = expected_frames.pop_front();
				if (left_out !== want.left) begin
					$error("left_out: expected %0d, actual %0d", want.left, left_out);
					mismatch_count++;
				end
				if (right_out !== want.right) begin
					$error("right_out: expected %0d, actual %0d", want.right, right_out);
					mismatch_count++;
				end
			end
		end
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Reset defaults, then full-scale frames, pan and gain extremes, zero
	// and wrapping delays, disabled taps and writes to unused indexes.
	task automatic test_directed();
		send_frame(16'sh7fff, 16'sh8000);
		send_frame(16'sh8000, 16'sh7fff);
		send_frame(16'sh0000, 16'shffff);
		drain_outputs();
		write_reg(REG_WORD_A0 + 0, pack_word_a(0, 1'b1, 16'hffff, 16'h8000));
		write_reg(REG_WORD_A0 + 1, pack_word_a(1, 1'b1, 16'hffff, 16'h7fff));
		write_reg(REG_WORD_A0 + 2, pack_word_a(RING, 1'b1, 16'h8000, 16'h0000));
		write_reg(REG_WORD_A0 + 3, pack_word_a(RING + 1, 1'b1, 16'h0000, 16'hc000));
		write_reg(REG_WORD_B0 + 0, pack_word_b(16'hffff, 16'h0000, 16'h0000));
		write_reg(REG_WORD_B0 + 1, pack_word_b(16'hffff, 16'hffff, 16'hffff));
		write_reg(REG_WORD_B0 + 2, pack_word_b(16'h8000, 16'h8000, 16'h5000));
		write_reg(REG_WORD_B0 + 3, pack_word_b(16'h0000, 16'h4000, 16'h0000));
		for (int i = 8; i < 16; i++)
			write_reg(i, '1);
		end_reg_writes();
		for (int i = 0; i < 8; i++)
			send_frame(i[0] ? 16'sh7fff : 16'sh8000, i[1] ? 16'sh8000 : 16'sh7fff);
		drain_outputs();
		// Disable two taps; their positions and lowpass state must hold.
		write_reg(REG_WORD_A0 + 1, pack_word_a(1, 1'b0, 16'hffff, 16'h7fff));
		write_reg(REG_WORD_A0 + 3, pack_word_a(3, 1'b0, 16'hffff, 16'h0000));
		end_reg_writes();
		for (int i = 0; i < 4; i++)
			send_random_frame();
		drain_outputs();
	endtask

	// Shorten a delay below the current feedback position.
	task automatic test_delay_shorten();
		write_reg(REG_WORD_A0 + 0, pack_word_a(20, 1'b1, 16'hc000, 16'h1000));
		write_reg(REG_WORD_B0 + 0, pack_word_b(16'hc000, 16'h3000, 16'h2000));
		end_reg_writes();
		for (int i = 0; i < 10; i++)
			send_random_frame();
		drain_outputs();
		write_reg(REG_WORD_A0 + 0, pack_word_a(3, 1'b1, 16'hc000, 16'h1000));
		end_reg_writes();
		for (int i = 0; i < 10; i++)
			send_random_frame();
		drain_outputs();
	endtask

	// Random settings and frames under one idling pattern.
	task automatic test_random_phase(int idle_pct, int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int s = 0; s < 4; s++) begin
			write_random_taps();
			for (int i = 0; i < 64; i++)
				send_random_frame();
			drain_outputs();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		reset_delay_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_delay_shorten();
		test_random_phase(0, 0);
		test_random_phase(48, 0);
		test_random_phase(0, 48);
		test_random_phase(13, 13);
		if (mismatch_count == 0 && expected_frames.size() == 0)
			$display("multitap_stereo_feedback_delay_top_tb passed");
		else
			$display("multitap_stereo_feedback_delay_top_tb failed");
		$finish;
	end

endmodule
